// ----- hdl/class_aware_box_nms_unit_macros.svh -----
// Assertion macros for the class-aware box NMS unit.
// Used by the top level; needs clk and rst_n in scope.
`ifndef CLASS_AWARE_BOX_NMS_UNIT_MACROS_SVH
`define CLASS_AWARE_BOX_NMS_UNIT_MACROS_SVH

// same-cycle implication
`define CABN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CABN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/cabn_pkg.sv -----
// Shared types, constants and box helpers for the class-aware box NMS unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cabn_pkg;

  localparam int MAX_DETECTIONS = 64;
  localparam int IDX_W = $clog2(MAX_DETECTIONS);
  localparam int CNT_W = $clog2(MAX_DETECTIONS + 1);

  localparam logic CFG_IOU_THR = 1'b0;
  localparam logic CFG_BOX_FMT = 1'b1;

  localparam logic [15:0] THR_RESET = 16'd29491;
  localparam logic FMT_CENTER = 1'b0;

  typedef enum logic [3:0] {
    S_LOAD, S_RK_I, S_RK_J0, S_RK_J,
    S_SP_I, S_SP_IA, S_SP_IB, S_SP_J, S_SP_JA, S_SP_JB, S_SP_W,
    S_EM_I, S_EM_A, S_EM_B
  } state_t;

  typedef struct packed {
    logic        start;
    logic        corner;
    logic [15:0] thr;
  } iou_ctl_t;

  typedef struct packed {
    logic signed [18:0] l;
    logic signed [18:0] t;
    logic signed [18:0] r;
    logic signed [18:0] b;
  } edges_t;

  // doubled-unit edges of a stored box {d, c, b, a}
  function automatic edges_t edges_of(input logic [63:0] box, input logic corner);
    edges_t e;
    logic signed [18:0] a2, b2, c1, d1, c2, d2;
    a2 = signed'({2'b0, box[15:0], 1'b0});
    b2 = signed'({2'b0, box[31:16], 1'b0});
    c1 = signed'({3'b0, box[47:32]});
    d1 = signed'({3'b0, box[63:48]});
    c2 = signed'({2'b0, box[47:32], 1'b0});
    d2 = signed'({2'b0, box[63:48], 1'b0});
    if (corner) begin
      e.l = a2; e.t = b2; e.r = c2; e.b = d2;
    end else begin
      e.l = a2 - c1; e.t = b2 - d1; e.r = a2 + c1; e.b = b2 + d1;
    end
    return e;
  endfunction

endpackage

`default_nettype wire

// ----- hdl/cabn_ram.sv -----
// Generic simple dual-port RAM, one write and one registered read per cycle.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module cabn_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- hdl/cabn_iou.sv -----
// Pipelined overlap test of two boxes: intersection > threshold * union.
// Depends on cabn_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cabn_iou (
  input  wire               clk,
  input  wire               rst_n,
  input  wire cabn_pkg::iou_ctl_t ctl,
  input  wire  [63:0]       box_p,
  input  wire  [63:0]       box_q,
  output logic              done,
  output logic              hit
);

  logic [5:0]         v_r;
  logic [63:0]        p_r, q_r;
  logic               corner_r;
  logic [15:0]        thr_r;
  // stage 1
  logic signed [19:0] w_r, h_r;
  logic signed [18:0] pw_r, ph_r, qw_r, qh_r;
  // stage 2
  logic [35:0]        inter_r;
  logic signed [37:0] ap_r, aq_r;
  // stage 3
  logic signed [39:0] uni_r;
  logic [35:0]        inter3_r;
  // stage 4
  logic [54:0]        prod_r;
  logic [35:0]        inter4_r;
  logic               ok_r;
  logic               hit_r;

  cabn_pkg::edges_t   ep, eq;
  logic signed [18:0] min_r, max_l, min_b, max_t;

  always_comb begin
    ep    = cabn_pkg::edges_of(p_r, corner_r);
    eq    = cabn_pkg::edges_of(q_r, corner_r);
    min_r = (ep.r < eq.r) ? ep.r : eq.r;
    max_l = (ep.l > eq.l) ? ep.l : eq.l;
    min_b = (ep.b < eq.b) ? ep.b : eq.b;
    max_t = (ep.t > eq.t) ? ep.t : eq.t;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[4:0], ctl.start};
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      p_r      <= box_p;
      q_r      <= box_q;
      corner_r <= ctl.corner;
      thr_r    <= ctl.thr;
    end
    w_r  <= 20'(min_r) - 20'(max_l);
    h_r  <= 20'(min_b) - 20'(max_t);
    pw_r <= ep.r - ep.l;
    ph_r <= ep.b - ep.t;
    qw_r <= eq.r - eq.l;
    qh_r <= eq.b - eq.t;
    // clip: no overlap on either axis means no intersection
    if (w_r[19] || h_r[19]) begin
      inter_r <= '0;
    end else begin
      inter_r <= w_r[17:0] * h_r[17:0];
    end
    ap_r     <= pw_r * ph_r;
    aq_r     <= qw_r * qh_r;
    uni_r    <= 40'(ap_r) + 40'(aq_r) - signed'({4'b0, inter_r});
    inter3_r <= inter_r;
    prod_r   <= thr_r * uni_r[38:0];
    ok_r     <= (inter3_r != '0) && !uni_r[39] && (uni_r != '0);
    inter4_r <= inter3_r;
    hit_r    <= ok_r && ({3'b0, inter4_r, 16'b0} > prod_r);
  end

  assign done = v_r[5];
  assign hit  = hit_r;

endmodule

`default_nettype wire

// ----- hdl/class_aware_box_nms_unit.sv -----
// Class-aware greedy box NMS over a set of up to 64 detections. Items load one
// a cycle into on-chip RAM; the item with last_in set starts the work. A rank
// pass reads the detection RAM once per entry pair, then suppression walks
// each class with a pipelined overlap unit, one compared pair at a time, and
// emission loads the result register once per result. The detection RAM has
// a single read port, so these passes read one entry at a time.
// Depends on cabn_pkg, cabn_ram, cabn_iou and the macros header.
`timescale 1ns / 1ps
`default_nettype none

`include "class_aware_box_nms_unit_macros.svh"

module class_aware_box_nms_unit (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_wr_en,
  input  wire                cfg_index,
  input  wire  [15:0]        cfg_data,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire  [7:0]         in_class_id,
  input  wire  [15:0]        in_score,
  input  wire  [15:0]        in_box_a,
  input  wire  [15:0]        in_box_b,
  input  wire  [15:0]        in_box_c,
  input  wire  [15:0]        in_box_d,
  input  wire                in_last_in,
  output logic               out_valid,
  input  wire                out_ready,
  output logic [7:0]         out_class,
  output logic [15:0]        out_score,
  output logic               out_kept,
  output logic signed [16:0] out_left_x,
  output logic signed [16:0] out_top_y,
  output logic [16:0]        out_right_x,
  output logic [16:0]        out_bottom_y,
  output logic               out_overflowed,
  output logic               out_last_out
);

  localparam int MAXD  = cabn_pkg::MAX_DETECTIONS;
  localparam int IDX_W = cabn_pkg::IDX_W;
  localparam int CNT_W = cabn_pkg::CNT_W;

  cabn_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt, i_r, i_nxt, j_r, j_nxt, rank_r, rank_nxt;
  logic             drop_r, drop_nxt;
  logic [23:0]      cur_meta_r, cur_meta_nxt;
  logic [63:0]      box_i_r, box_i_nxt;
  logic [MAXD-1:0]  kept_r, kept_nxt;
  logic [15:0]      thr_r;
  logic             fmt_r;
  logic             out_load;

  // RAM ports
  logic             det_we, ord_we;
  logic [IDX_W-1:0] det_waddr, det_raddr, ord_waddr, ord_raddr;
  logic [63:0]      box_rdata;
  logic [23:0]      meta_rdata;
  logic [IDX_W-1:0] ord_rdata;

  cabn_pkg::iou_ctl_t iou_ctl;
  logic               iou_done, iou_hit;

  logic               in_acc, goes_first, em_kept;
  logic [CNT_W-1:0]   j_prev;

  cabn_ram #(.DEPTH(MAXD), .WIDTH(64)) u_box_ram (
    .clk(clk), .we(det_we), .waddr(det_waddr),
    .wdata({in_box_d, in_box_c, in_box_b, in_box_a}),
    .raddr(det_raddr), .rdata(box_rdata)
  );

  cabn_ram #(.DEPTH(MAXD), .WIDTH(24)) u_meta_ram (
    .clk(clk), .we(det_we), .waddr(det_waddr),
    .wdata({in_class_id, in_score}),
    .raddr(det_raddr), .rdata(meta_rdata)
  );

  cabn_ram #(.DEPTH(MAXD), .WIDTH(IDX_W)) u_order_ram (
    .clk(clk), .we(ord_we), .waddr(ord_waddr), .wdata(i_r[IDX_W-1:0]),
    .raddr(ord_raddr), .rdata(ord_rdata)
  );

  cabn_iou u_iou (
    .clk(clk), .rst_n(rst_n), .ctl(iou_ctl),
    .box_p(box_i_r), .box_q(box_rdata), .done(iou_done), .hit(iou_hit)
  );

  assign in_ready = (state_r == cabn_pkg::S_LOAD);
  assign in_acc   = in_valid && in_ready;
  assign j_prev   = j_r - CNT_W'(1);

  // entry j-1 goes before entry i: class up, score down, arrival order
  always_comb begin
    goes_first = (meta_rdata[23:16] < cur_meta_r[23:16]) ||
                 ((meta_rdata[23:16] == cur_meta_r[23:16]) &&
                  ((meta_rdata[15:0] > cur_meta_r[15:0]) ||
                   ((meta_rdata[15:0] == cur_meta_r[15:0]) && (j_prev < i_r))));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= cabn_pkg::S_LOAD;
      cnt_r     <= '0;
      drop_r    <= 1'b0;
      i_r       <= '0;
      j_r       <= '0;
      rank_r    <= '0;
      kept_r    <= '0;
      thr_r     <= cabn_pkg::THR_RESET;
      fmt_r     <= cabn_pkg::FMT_CENTER;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      drop_r  <= drop_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
      rank_r  <= rank_nxt;
      kept_r  <= kept_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          cabn_pkg::CFG_IOU_THR: thr_r <= cfg_data;
          cabn_pkg::CFG_BOX_FMT: fmt_r <= cfg_data[0];
          default: ;
        endcase
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_meta_r <= cur_meta_nxt;
    box_i_r    <= box_i_nxt;
  end

  // result register, loaded once per emitted entry
  assign em_kept = kept_r[i_r[IDX_W-1:0]];
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_class      <= meta_rdata[23:16];
      out_score      <= em_kept ? meta_rdata[15:0] : 16'd0;
      out_kept       <= em_kept;
      out_overflowed <= drop_r;
      out_last_out   <= (i_r + CNT_W'(1) == cnt_r);
      if (em_kept && (fmt_r == cabn_pkg::FMT_CENTER)) begin
        out_left_x   <= signed'({1'b0, box_rdata[15:0]} - {2'b0, box_rdata[47:33]});
        out_top_y    <= signed'({1'b0, box_rdata[31:16]} - {2'b0, box_rdata[63:49]});
        out_right_x  <= {1'b0, box_rdata[15:0]} + {2'b0, box_rdata[47:33]};
        out_bottom_y <= {1'b0, box_rdata[31:16]} + {2'b0, box_rdata[63:49]};
      end else begin
        out_left_x   <= signed'({1'b0, box_rdata[15:0]});
        out_top_y    <= signed'({1'b0, box_rdata[31:16]});
        out_right_x  <= {1'b0, box_rdata[47:32]};
        out_bottom_y <= {1'b0, box_rdata[63:48]};
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    drop_nxt     = drop_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    rank_nxt     = rank_r;
    kept_nxt     = kept_r;
    cur_meta_nxt = cur_meta_r;
    box_i_nxt    = box_i_r;
    det_we       = 1'b0;
    det_waddr    = cnt_r[IDX_W-1:0];
    det_raddr    = i_r[IDX_W-1:0];
    ord_we       = 1'b0;
    ord_waddr    = rank_r[IDX_W-1:0];
    ord_raddr    = i_r[IDX_W-1:0];
    iou_ctl      = '{start: 1'b0, corner: fmt_r, thr: thr_r};
    out_load     = 1'b0;

    case (state_r)
      cabn_pkg::S_LOAD: begin
        if (in_acc) begin
          if (cnt_r < CNT_W'(MAXD)) begin
            det_we  = 1'b1;
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_in) begin
            i_nxt     = '0;
            state_nxt = cabn_pkg::S_RK_I;
          end
        end
      end
      cabn_pkg::S_RK_I: begin
        det_raddr = i_r[IDX_W-1:0];
        state_nxt = cabn_pkg::S_RK_J0;
      end
      cabn_pkg::S_RK_J0: begin
        cur_meta_nxt = meta_rdata;
        det_raddr    = '0;
        j_nxt        = CNT_W'(1);
        rank_nxt     = '0;
        state_nxt    = cabn_pkg::S_RK_J;
      end
      cabn_pkg::S_RK_J: begin
        rank_nxt = rank_r + CNT_W'(goes_first);
        if (j_r == cnt_r) begin
          // rank settled: place entry i there
          ord_we    = 1'b1;
          ord_waddr = rank_nxt[IDX_W-1:0];
          i_nxt     = i_r + CNT_W'(1);
          if (i_r + CNT_W'(1) == cnt_r) begin
            i_nxt     = '0;
            kept_nxt  = '1;
            state_nxt = cabn_pkg::S_SP_I;
          end else begin
            state_nxt = cabn_pkg::S_RK_I;
          end
        end else begin
          det_raddr = j_r[IDX_W-1:0];
          j_nxt     = j_r + CNT_W'(1);
        end
      end
      cabn_pkg::S_SP_I: begin
        if (i_r == cnt_r) begin
          i_nxt     = '0;
          state_nxt = cabn_pkg::S_EM_I;
        end else if (!kept_r[i_r[IDX_W-1:0]]) begin
          i_nxt = i_r + CNT_W'(1);
        end else begin
          ord_raddr = i_r[IDX_W-1:0];
          state_nxt = cabn_pkg::S_SP_IA;
        end
      end
      cabn_pkg::S_SP_IA: begin
        det_raddr = ord_rdata;
        state_nxt = cabn_pkg::S_SP_IB;
      end
      cabn_pkg::S_SP_IB: begin
        box_i_nxt    = box_rdata;
        cur_meta_nxt = meta_rdata;
        j_nxt        = i_r + CNT_W'(1);
        state_nxt    = cabn_pkg::S_SP_J;
      end
      cabn_pkg::S_SP_J: begin
        if (j_r == cnt_r) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = cabn_pkg::S_SP_I;
        end else begin
          ord_raddr = j_r[IDX_W-1:0];
          state_nxt = cabn_pkg::S_SP_JA;
        end
      end
      cabn_pkg::S_SP_JA: begin
        det_raddr = ord_rdata;
        state_nxt = cabn_pkg::S_SP_JB;
      end
      cabn_pkg::S_SP_JB: begin
        // class run ends: move on to the next survivor
        if (meta_rdata[23:16] != cur_meta_r[23:16]) begin
          i_nxt     = i_r + CNT_W'(1);
          state_nxt = cabn_pkg::S_SP_I;
        end else if (!kept_r[j_r[IDX_W-1:0]]) begin
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = cabn_pkg::S_SP_J;
        end else begin
          iou_ctl.start = 1'b1;
          state_nxt     = cabn_pkg::S_SP_W;
        end
      end
      cabn_pkg::S_SP_W: begin
        if (iou_done) begin
          if (iou_hit) begin
            kept_nxt[j_r[IDX_W-1:0]] = 1'b0;
          end
          j_nxt     = j_r + CNT_W'(1);
          state_nxt = cabn_pkg::S_SP_J;
        end
      end
      cabn_pkg::S_EM_I: begin
        if (!out_valid || out_ready) begin
          ord_raddr = i_r[IDX_W-1:0];
          state_nxt = cabn_pkg::S_EM_A;
        end
      end
      cabn_pkg::S_EM_A: begin
        det_raddr = ord_rdata;
        state_nxt = cabn_pkg::S_EM_B;
      end
      cabn_pkg::S_EM_B: begin
        out_load = 1'b1;
        i_nxt    = i_r + CNT_W'(1);
        if (i_r + CNT_W'(1) == cnt_r) begin
          cnt_nxt   = '0;
          drop_nxt  = 1'b0;
          state_nxt = cabn_pkg::S_LOAD;
        end else begin
          state_nxt = cabn_pkg::S_EM_I;
        end
      end
      default: state_nxt = cabn_pkg::S_LOAD;
    endcase
  end

  `CABN_ASSERT_NOW(a_count_bound, 1'b1, cnt_r <= CNT_W'(MAXD), "entry count beyond capacity")
  `CABN_ASSERT_NOW(a_iou_done_wait, iou_done, state_r == cabn_pkg::S_SP_W, "stray overlap result")
  `CABN_ASSERT_NEXT(a_last_rank, in_acc && in_last_in, state_r == cabn_pkg::S_RK_I, "no ranking")
  `CABN_ASSERT_NOW(a_out_emit, $rose(out_valid), $past(state_r == cabn_pkg::S_EM_B), "stray result")

endmodule

`default_nettype wire

// ----- tb/sv/class_aware_box_nms_unit_checker.sv -----
// Watches both channels of the box NMS unit, predicts the emitted detections
// of each set and compares them field by field. Depends on cabn_pkg.
`timescale 1ns / 1ps

module class_aware_box_nms_unit_checker (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               cfg_wr_en,
  input  wire               cfg_index,
  input  wire  [15:0]       cfg_data,
  input  wire               in_valid,
  input  wire               in_ready,
  input  wire  [7:0]        in_class_id,
  input  wire  [15:0]       in_score,
  input  wire  [15:0]       in_box_a,
  input  wire  [15:0]       in_box_b,
  input  wire  [15:0]       in_box_c,
  input  wire  [15:0]       in_box_d,
  input  wire               in_last_in,
  input  wire               out_valid,
  input  wire               out_ready,
  input  wire  [7:0]        out_class,
  input  wire  [15:0]       out_score,
  input  wire               out_kept,
  input  wire  [16:0]       out_left_x,
  input  wire  [16:0]       out_top_y,
  input  wire  [16:0]       out_right_x,
  input  wire  [16:0]       out_bottom_y,
  input  wire               out_overflowed,
  input  wire               out_last_out,
  output int                fail_count,
  output int                pending_count
);

  typedef struct packed {
    logic [7:0]  cls;
    logic [15:0] score;
    logic        kept;
    logic [16:0] l, t, r, b;
    logic        ovf;
    logic        last;
  } det_out_t;

  logic [7:0]  set_cls [cabn_pkg::MAX_DETECTIONS];
  logic [15:0] set_score [cabn_pkg::MAX_DETECTIONS];
  logic [15:0] set_box [cabn_pkg::MAX_DETECTIONS][4];
  int          set_count;
  logic        set_dropped;
  logic [15:0] thr;
  logic        corner;
  det_out_t    expected_dets[$];

  assign pending_count = expected_dets.size();

  function automatic void box_edges(input int e, output longint ed[4]);
    longint a, b, c, d;
    a = set_box[e][0]; b = set_box[e][1]; c = set_box[e][2]; d = set_box[e][3];
    if (corner) begin
      ed[0] = 2*a; ed[1] = 2*b; ed[2] = 2*c; ed[3] = 2*d;
    end else begin
      ed[0] = 2*a - c; ed[1] = 2*b - d; ed[2] = 2*a + c; ed[3] = 2*b + d;
    end
  endfunction

  function automatic bit too_close(input int p, input int q);
    longint ep[4], eq[4];
    longint w, h, isect, uni;
    box_edges(p, ep);
    box_edges(q, eq);
    w = (ep[2] < eq[2] ? ep[2] : eq[2]) - (ep[0] > eq[0] ? ep[0] : eq[0]);
    h = (ep[3] < eq[3] ? ep[3] : eq[3]) - (ep[1] > eq[1] ? ep[1] : eq[1]);
    isect = (w < 0 || h < 0) ? 0 : w * h;
    uni = (ep[2]-ep[0])*(ep[3]-ep[1]) + (eq[2]-eq[0])*(eq[3]-eq[1]) - isect;
    if (isect <= 0 || uni <= 0) return 1'b0;
    return isect * 65536 > longint'(thr) * uni;
  endfunction

  function automatic bit ranks_ahead(input int x, input int y);
    if (set_cls[x] != set_cls[y]) return set_cls[x] < set_cls[y];
    return set_score[x] > set_score[y];
  endfunction

  // sort, suppress within each class, queue the emitted detections
  task automatic predict_set();
    int order[cabn_pkg::MAX_DETECTIONS];
    bit keep[cabn_pkg::MAX_DETECTIONS];
    int i, j, e;
    longint a, b, c, d, l, t;
    det_out_t r;
    for (i = 0; i < set_count; i++) begin
      j = i;
      while (j > 0 && ranks_ahead(i, order[j-1])) begin
        order[j] = order[j-1];
        j--;
      end
      order[j] = i;
    end
    for (i = 0; i < set_count; i++) keep[i] = 1'b1;
    for (i = 0; i < set_count; i++) begin
      if (keep[i])
        for (j = i + 1; j < set_count && set_cls[order[j]] == set_cls[order[i]]; j++)
          if (keep[j] && too_close(order[i], order[j])) keep[j] = 1'b0;
    end
    for (i = 0; i < set_count; i++) begin
      e = order[i];
      a = set_box[e][0]; b = set_box[e][1]; c = set_box[e][2]; d = set_box[e][3];
      if (keep[i] && !corner) begin
        l = a - (c >> 1); t = b - (d >> 1);
        c = a + (c >> 1); d = b + (d >> 1);
        a = l; b = t;
      end
      r.cls = set_cls[e];
      r.score = keep[i] ? set_score[e] : 16'd0;
      r.kept = keep[i];
      r.l = a[16:0]; r.t = b[16:0]; r.r = c[16:0]; r.b = d[16:0];
      r.ovf = set_dropped;
      r.last = (i + 1 == set_count);
      expected_dets.push_back(r);
    end
    set_count = 0;
    set_dropped = 1'b0;
  endtask

  always @(posedge clk) begin
    det_out_t got, want;
    if (!rst_n) begin
      set_count = 0;
      set_dropped = 1'b0;
      thr = cabn_pkg::THR_RESET;
      corner = cabn_pkg::FMT_CENTER;
      fail_count <= 0;
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == cabn_pkg::CFG_IOU_THR) thr = cfg_data;
        else corner = cfg_data[0];
      end
      if (in_valid && in_ready) begin
        if (set_count < cabn_pkg::MAX_DETECTIONS) begin
          set_cls[set_count] = in_class_id;
          set_score[set_count] = in_score;
          set_box[set_count][0] = in_box_a;
          set_box[set_count][1] = in_box_b;
          set_box[set_count][2] = in_box_c;
          set_box[set_count][3] = in_box_d;
          set_count = set_count + 1;
        end else begin
          set_dropped = 1'b1;
        end
        if (in_last_in) predict_set();
      end
      if (out_valid && out_ready) begin
        got = {out_class, out_score, out_kept, out_left_x, out_top_y, out_right_x,
               out_bottom_y, out_overflowed, out_last_out};
        if (expected_dets.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected detection out: %p", got);
        end else begin
          want = expected_dets.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10) $display("mismatch: expected %p got %p", want, got);
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/class_aware_box_nms_unit_tb.sv -----
// Stimulus and verdict for the class-aware box NMS unit: sets of detections,
// register changes between sets, random idling. Depends on cabn_pkg, the unit and the checker.
`timescale 1ns / 1ps

module class_aware_box_nms_unit_tb;

  logic clk, rst_n;
  logic cfg_wr_en, cfg_index;
  logic [15:0] cfg_data;
  logic in_valid, in_ready;
  logic [7:0] in_class_id;
  logic [15:0] in_score, in_box_a, in_box_b, in_box_c, in_box_d;
  logic in_last_in;
  logic out_valid, out_ready;
  logic [7:0] out_class;
  logic [15:0] out_score;
  logic out_kept, out_overflowed, out_last_out;
  logic signed [16:0] out_left_x, out_top_y;
  logic [16:0] out_right_x, out_bottom_y;
  int fail_count, pending_count;
  int quiet_cycles;
  bit calm;
  int sent;

  class_aware_box_nms_unit DUT (.*);
  class_aware_box_nms_unit_checker checker_i (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 100000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // receiver stalls in bursts
  initial begin
    int n;
    out_ready = 0;
    forever begin
      @(negedge clk);
      if (!calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 0;
        n = $urandom_range(1, 9);
        repeat (n - 1) @(negedge clk);
      end else out_ready <= 1;
    end
  end

  // hold valid after a handshake when the next item follows at once
  task automatic send_det(input logic [7:0] c, input logic [15:0] s,
                          input logic [15:0] a, b, cc, d, input logic lst);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      n = $urandom_range(1, 9);
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_class_id <= c; in_score <= s;
    in_box_a <= a; in_box_b <= b; in_box_c <= cc; in_box_d <= d;
    in_last_in <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent++;
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] v);
    cfg_wr_en <= 1'b1; cfg_index <= idx; cfg_data <= v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (50) @(negedge clk);
  endtask

  // one set of clustered boxes so that overlaps are common
  task automatic random_set(input int n);
    logic [15:0] bx, by;
    int ncls;
    ncls = $urandom_range(1, 3);
    bx = 16'($urandom_range(0, 2000)); by = 16'($urandom_range(0, 2000));
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0)
        send_det(8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom), i == n-1);
      else
        send_det(8'($urandom_range(0, ncls)), 16'($urandom),
                 16'(bx + $urandom_range(0, 200)), 16'(by + $urandom_range(0, 200)),
                 16'($urandom_range(0, 600)), 16'($urandom_range(0, 600)), i == n-1);
    end
  endtask

  initial begin
    rst_n = 0; calm = 0; sent = 0; quiet_cycles = 0;
    cfg_wr_en = 0; cfg_index = cabn_pkg::CFG_IOU_THR; cfg_data = 0;
    in_valid = 0; in_class_id = 0; in_score = 0;
    in_box_a = 0; in_box_b = 0; in_box_c = 0; in_box_d = 0; in_last_in = 0;
    repeat (2) @(negedge clk);
    rst_n = 1;
    // directed: single box, extremes, ties, zero scores, zero-size boxes
    send_det(8'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    send_det(8'd255, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_det(8'd5, 16'd100, 16'd100, 16'd100, 16'd40, 16'd40, 1'b0);
    send_det(8'd5, 16'd100, 16'd101, 16'd100, 16'd40, 16'd40, 1'b0);
    send_det(8'd5, 16'd0, 16'd100, 16'd100, 16'd40, 16'd40, 1'b0);
    send_det(8'd5, 16'd900, 16'd500, 16'd500, 16'd0, 16'd10, 1'b0);
    send_det(8'd255, 16'hFFFF, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 1'b1);
    drain();
    write_reg(cabn_pkg::CFG_BOX_FMT, 16'd1);
    write_reg(cabn_pkg::CFG_IOU_THR, 16'd0);
    send_det(8'd1, 16'd50, 16'd0, 16'd0, 16'd10, 16'd10, 1'b0);
    send_det(8'd1, 16'd60, 16'd9, 16'd9, 16'd20, 16'd20, 1'b0);
    send_det(8'd1, 16'd70, 16'd30, 16'd30, 16'd20, 16'd20, 1'b0);
    send_det(8'd2, 16'd70, 16'd30, 16'd30, 16'd20, 16'd20, 1'b1);
    drain();
    write_reg(cabn_pkg::CFG_IOU_THR, 16'hFFFF);
    send_det(8'd3, 16'd1, 16'd0, 16'd0, 16'd10, 16'd10, 1'b0);
    send_det(8'd3, 16'd2, 16'd0, 16'd0, 16'd10, 16'd10, 1'b1);
    drain();
    // overflow: 66 items, the last two dropped
    write_reg(cabn_pkg::CFG_BOX_FMT, 16'd0);
    write_reg(cabn_pkg::CFG_IOU_THR, cabn_pkg::THR_RESET);
    random_set(66);
    drain();
    while (sent < 400) begin
      if ($urandom_range(0, 2) == 0) begin
        write_reg(cabn_pkg::CFG_IOU_THR,
                  $urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom));
        write_reg(cabn_pkg::CFG_BOX_FMT, 16'($urandom_range(0, 1)));
      end
      if (sent > 340) calm = 1;
      random_set(int'($urandom_range(1, 12)));
      drain();
    end
    drain();
    if (fail_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cabn_pkg.sv
hdl/cabn_ram.sv
hdl/cabn_iou.sv
hdl/class_aware_box_nms_unit.sv
tb/sv/class_aware_box_nms_unit_checker.sv
tb/sv/class_aware_box_nms_unit_tb.sv
